[rtl/tmi_pkg.sv]
`default_nettype none
package tmi_pkg;
	typedef enum logic [3:0] {
		ST_RUN = 4'd0, ST_HALT = 4'd1, ST_OVER = 4'd2, ST_UNDER = 4'd3,
		ST_UNCLOSE = 4'd4, ST_UNOPEN = 4'd5, ST_WAIT = 4'd6, ST_FULL = 4'd7,
		ST_DEEP = 4'd8
	} status_t;

	localparam logic [7:0] SYM_INC = 8'h2B;
	localparam logic [7:0] SYM_DEC = 8'h2D;
	localparam logic [7:0] SYM_RIGHT = 8'h3E;
	localparam logic [7:0] SYM_LEFT = 8'h3C;
	localparam logic [7:0] SYM_OUT = 8'h2E;
	localparam logic [7:0] SYM_IN = 8'h2C;
	localparam logic [7:0] SYM_OPEN = 8'h5B;
	localparam logic [7:0] SYM_CLOSE = 8'h5D;

	typedef enum logic [2:0] {
		FSM_CLEAR, FSM_IDLE, FSM_FETCH, FSM_EXEC, FSM_SCAN, FSM_POP, FSM_OUT
	} fsm_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic fetch;
		logic exec;
		logic scan;
		logic pop;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic load_now;
		logic idle_done;
		logic exec_scan;
		logic exec_pop;
		logic scan_done;
	} stat_t;

	typedef struct packed {
		logic [7:0] output_byte;
		logic output_valid;
		logic input_taken;
		logic [3:0] status;
		logic [12:0] program_counter;
	} res_t;
endpackage
`default_nettype wire

[rtl/tmi_if.sv]
`default_nettype none
interface tmi_in_if;
	logic valid;
	logic ready;
	logic operation;
	logic [7:0] program_byte;
	logic [7:0] input_byte;
	logic input_valid;
	modport source(output valid, operation, program_byte, input_byte, input_valid, input ready);
	modport sink(input valid, operation, program_byte, input_byte, input_valid, output ready);
endinterface

interface tmi_out_if;
	logic valid;
	logic ready;
	logic [7:0] output_byte;
	logic output_valid;
	logic input_taken;
	logic [3:0] status;
	logic [12:0] program_counter;
	modport source(output valid, output_byte, output_valid, input_taken, status,
		program_counter, input ready);
	modport sink(input valid, output_byte, output_valid, input_taken, status,
		program_counter, output ready);
endinterface
`default_nettype wire

[rtl/tape_machine_interpreter.sv]
`default_nettype none
// Tape language interpreter.
// Channel "in" carries operation, program_byte, input_byte and input_valid;
// channel "out" returns one result per accepted item. Both use valid/ready,
// a transfer happening when both are high.
// A load, a halted step or any item under a sticky error goes from idle
// straight to the result state. An ordinary symbol passes through fetch
// (program and tape read), execute and result. A close bracket with an open
// loop adds a pop state for the loop stack read. An open bracket on a zero
// cell scans forward one program byte per cycle, so its latency grows with
// the distance to the match. One item is in flight at a time; in.ready is
// high only while idle. After reset the tape is swept to zero at one cell
// per cycle, and in.ready stays low until the sweep ends.
// The result waits in the output register while out.ready is low; no new
// item is taken until it transfers.
module tape_machine_interpreter #(
	parameter int TAPE_CELLS = 32768,
	parameter int PROGRAM_BYTES = 4096,
	parameter int LOOP_NESTING = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	tmi_in_if.sink in,
	tmi_out_if.source out
);
	import tmi_pkg::*;
	cmd_t cmd;
	stat_t st;
	res_t res;
	logic busy;

	assign in.ready = !busy;
	assign out.valid = busy && !cmd.clear && !cmd.fetch && !cmd.exec && !cmd.scan && !cmd.pop;
	assign out.output_byte = res.output_byte;
	assign out.output_valid = res.output_valid;
	assign out.input_taken = res.input_taken;
	assign out.status = res.status;
	assign out.program_counter = res.program_counter;

	tmi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in.valid && in.ready),
		.out_free(out.ready), .st(st), .cmd(cmd), .busy_out(busy)
	);

	tmi_datapath #(
		.TAPE_CELLS(TAPE_CELLS), .PROGRAM_BYTES(PROGRAM_BYTES), .LOOP_NESTING(LOOP_NESTING)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .operation(in.operation),
		.program_byte(in.program_byte), .input_byte(in.input_byte),
		.input_valid(in.input_valid), .st(st), .res(res)
	);
endmodule
`default_nettype wire

[rtl/tmi_ctrl.sv]
`default_nettype none
module tmi_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_fire,
	input wire logic out_free,
	input wire tmi_pkg::stat_t st,
	output tmi_pkg::cmd_t cmd,
	output logic busy_out
);
	import tmi_pkg::*;
	fsm_t state_q, nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FSM_CLEAR;
		else state_q <= nxt;
	end

	always_comb begin
		nxt = state_q;
		unique case (state_q)
			FSM_CLEAR: if (st.clear_done) nxt = FSM_IDLE;
			FSM_IDLE: if (in_fire) begin
				if (st.load_now || st.idle_done) nxt = FSM_OUT;
				else nxt = FSM_FETCH;
			end
			FSM_FETCH: nxt = FSM_EXEC;
			FSM_EXEC: begin
				if (st.exec_scan) nxt = FSM_SCAN;
				else if (st.exec_pop) nxt = FSM_POP;
				else nxt = FSM_OUT;
			end
			FSM_SCAN: if (st.scan_done) nxt = FSM_OUT;
			FSM_POP: nxt = FSM_OUT;
			FSM_OUT: if (out_free) nxt = FSM_IDLE;
			default: nxt = FSM_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy_out = 1'b1;
		unique case (state_q)
			FSM_CLEAR: cmd.clear = 1'b1;
			FSM_IDLE: begin
				busy_out = 1'b0;
				cmd.load = in_fire;
			end
			FSM_FETCH: cmd.fetch = 1'b1;
			FSM_EXEC: cmd.exec = 1'b1;
			FSM_SCAN: cmd.scan = 1'b1;
			FSM_POP: cmd.pop = 1'b1;
			FSM_OUT: ;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

[rtl/tmi_datapath.sv]
`default_nettype none
module tmi_datapath #(
	parameter int TAPE_CELLS = 32768,
	parameter int PROGRAM_BYTES = 4096,
	parameter int LOOP_NESTING = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire tmi_pkg::cmd_t cmd,
	input wire logic operation,
	input wire logic [7:0] program_byte,
	input wire logic [7:0] input_byte,
	input wire logic input_valid,
	output tmi_pkg::stat_t st,
	output tmi_pkg::res_t res
);
	import tmi_pkg::*;
	localparam int TW = $clog2(TAPE_CELLS);
	localparam int PW = $clog2(PROGRAM_BYTES);
	localparam int PLW = PW + 1;
	localparam int LW = $clog2(LOOP_NESTING);
	localparam int DW = LW + 1;

	logic [7:0] prog_mem [PROGRAM_BYTES];
	logic [7:0] tape_mem [TAPE_CELLS];
	logic [PW-1:0] stack_mem [LOOP_NESTING];

	logic [PLW-1:0] plen_q, ip_q;
	logic [TW-1:0] cp_q;
	logic [DW-1:0] depth_q;
	status_t run_q;
	logic [TW:0] clr_q;
	logic [7:0] sym_q, cell_q;
	logic [PW-1:0] pop_q;
	logic [PLW-1:0] scan_q;
	logic [PLW-1:0] level_q;
	logic inb_valid_q;
	logic [7:0] inb_q;

	// Program port address: scan cursor during a scan, else instruction pointer.
	logic [PLW-1:0] paddr;
	assign paddr = cmd.scan ? scan_q : ip_q;

	assign st.clear_done = clr_q[TW];
	assign st.load_now = (run_q != ST_RUN) || !operation;
	assign st.idle_done = operation && (ip_q >= plen_q);
	assign st.exec_scan = (run_q == ST_RUN) && sym_q == SYM_OPEN && cell_q == 8'd0;
	assign st.exec_pop = sym_q == SYM_CLOSE && depth_q != '0;
	assign st.scan_done = (scan_q >= plen_q) || (sym_q == SYM_CLOSE && level_q == PLW'(1));

	always_ff @(posedge clk) begin
		if (cmd.clear) tape_mem[clr_q[TW-1:0]] <= 8'd0;
		else if (cmd.exec && run_q == ST_RUN) begin
			if (sym_q == SYM_INC) tape_mem[cp_q] <= cell_q + 8'd1;
			else if (sym_q == SYM_DEC) tape_mem[cp_q] <= cell_q - 8'd1;
			else if (sym_q == SYM_IN && inb_valid_q) tape_mem[cp_q] <= inb_q;
		end
		cell_q <= tape_mem[cp_q];
		if (cmd.load && run_q == ST_RUN && !operation && plen_q < PLW'(PROGRAM_BYTES))
			prog_mem[plen_q[PW-1:0]] <= program_byte;
		sym_q <= prog_mem[paddr[PW-1:0]];
		if (cmd.exec && run_q == ST_RUN && sym_q == SYM_OPEN && cell_q != 8'd0 &&
			depth_q < DW'(LOOP_NESTING))
			stack_mem[depth_q[LW-1:0]] <= ip_q[PW-1:0];
		pop_q <= stack_mem[depth_q[LW-1:0] - LW'(1)];
		if (cmd.load) begin
			inb_q <= input_byte;
			inb_valid_q <= input_valid;
		end
	end

	// sym_q during a scan holds the byte at scan_q-1, as the read is registered;
	// scan_q leads the read data by one, so level checks use the byte just fetched.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0; ip_q <= '0; cp_q <= '0; depth_q <= '0;
			run_q <= ST_RUN; clr_q <= '0; scan_q <= '0; level_q <= '0;
			res <= '0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + (TW+1)'(1);
			if (cmd.load) begin
				res <= '0;
				res.program_counter <= 13'(ip_q);
				if (run_q != ST_RUN) res.status <= run_q;
				else if (!operation) begin
					if (plen_q >= PLW'(PROGRAM_BYTES)) begin
						run_q <= ST_FULL; res.status <= ST_FULL;
					end else plen_q <= plen_q + PLW'(1);
				end else if (ip_q >= plen_q) begin
					if (depth_q != '0) begin
						run_q <= ST_UNOPEN; res.status <= ST_UNOPEN;
					end else res.status <= ST_HALT;
				end
			end
			if (cmd.exec) begin
				res.program_counter <= 13'(ip_q + PLW'(1));
				ip_q <= ip_q + PLW'(1);
				case (sym_q)
					SYM_RIGHT: if (cp_q == TW'(TAPE_CELLS - 1)) begin
						run_q <= ST_OVER; res.status <= ST_OVER;
						ip_q <= ip_q; res.program_counter <= 13'(ip_q);
					end else cp_q <= cp_q + TW'(1);
					SYM_LEFT: if (cp_q == '0) begin
						run_q <= ST_UNDER; res.status <= ST_UNDER;
						ip_q <= ip_q; res.program_counter <= 13'(ip_q);
					end else cp_q <= cp_q - TW'(1);
					SYM_OUT: begin
						res.output_byte <= cell_q; res.output_valid <= 1'b1;
					end
					SYM_IN: if (inb_valid_q) res.input_taken <= 1'b1;
					else begin
						res.status <= ST_WAIT;
						ip_q <= ip_q; res.program_counter <= 13'(ip_q);
					end
					SYM_OPEN: if (cell_q != 8'd0) begin
						if (depth_q >= DW'(LOOP_NESTING)) begin
							run_q <= ST_DEEP; res.status <= ST_DEEP;
							ip_q <= ip_q; res.program_counter <= 13'(ip_q);
						end else depth_q <= depth_q + DW'(1);
					end else begin
						ip_q <= ip_q;
						res.program_counter <= 13'(ip_q);
						scan_q <= ip_q + PLW'(1);
						level_q <= PLW'(1);
					end
					SYM_CLOSE: if (depth_q == '0) begin
						run_q <= ST_UNCLOSE; res.status <= ST_UNCLOSE;
						ip_q <= ip_q; res.program_counter <= 13'(ip_q);
					end else depth_q <= depth_q - DW'(1);
					default: ;
				endcase
			end
			if (cmd.pop) begin
				ip_q <= PLW'(pop_q);
				res.program_counter <= 13'(pop_q);
			end
			if (cmd.scan) begin
				// First scan cycle: sym_q still holds '[' read at ip_q.
				if (sym_q == SYM_CLOSE && level_q == PLW'(1) &&
					scan_q != ip_q + PLW'(1)) begin
					ip_q <= scan_q; res.program_counter <= 13'(scan_q);
				end else if (scan_q >= plen_q) begin
					run_q <= ST_UNOPEN; res.status <= ST_UNOPEN;
				end else begin
					scan_q <= scan_q + PLW'(1);
					if (scan_q != ip_q + PLW'(1)) begin
						if (sym_q == SYM_OPEN) level_q <= level_q + PLW'(1);
						else if (sym_q == SYM_CLOSE) level_q <= level_q - PLW'(1);
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

[rtl/tmi_checker.sv]
`default_nettype none
module tmi_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [3:0] status,
	input wire logic output_valid,
	input wire logic input_taken
);
	import tmi_pkg::*;
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("stalled result changed");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(output_valid && input_taken))
		else $error("emit and take together");
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (output_valid || input_taken) |-> status == ST_RUN)
		else $error("data flag with error status");
endmodule

bind tape_machine_interpreter tmi_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready), .status(out.status),
	.output_valid(out.output_valid), .input_taken(out.input_taken)
);
`default_nettype wire
